// ===== rtl/core/gcpm_pkg.sv =====
// Shared types and codes of the greedy column pair matcher.
// Holds the input and result beat structs, the lane control struct and the register indexes.
// No dependencies.
package gcpm_pkg;

  // Configuration register indexes.
  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;
  localparam int   CFG_DATA_W      = 9;

  typedef struct packed {
    logic [7:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] ref_value;
    logic signed [15:0] alt_value;
    logic               load_done;
  } in_t;

  typedef struct packed {
    logic [4:0] ref_col;
    logic [4:0] alt_col;
    logic       last_pair;
  } out_t;

  // Per-cycle controls broadcast from the sequencer to every lane.
  typedef struct packed {
    logic issue;     // read one row of the column stores
    logic mul_en;    // read data is valid, form the product
    logic acc_en;    // product is valid, accumulate it
    logic acc_clr;   // clear the accumulator
    logic score_wr;  // write the accumulator into the score store
    logic scan_rd;   // read one score for the greedy scan
    logic scan_clr;  // reset the running best at the start of a round
    logic scan_cmp;  // compare the score read last cycle (its reference column is still free)
  } lane_ctl_t;

endpackage

// ===== rtl/core/gcpm_lane.sv =====
// One lane of the matcher: owns one alternative column, its dot-product MAC,
// the scores of that column against every reference column, and a running best.
// Depends on gcpm_pkg.
module gcpm_lane #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 16,
  parameter int VALUE_BITS = 16,
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int SCORE_W   = 2 * VALUE_BITS + $clog2(MAX_ROWS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gcpm_pkg::lane_ctl_t          ctl_i,
  input  logic                         alt_we_i,
  input  logic [ROW_W-1:0]             alt_waddr_i,
  input  logic signed [VALUE_BITS-1:0] alt_wdata_i,
  input  logic [ROW_W-1:0]             rd_row_i,
  input  logic signed [VALUE_BITS-1:0] ref_rd_i,
  input  logic [COL_W-1:0]             col_i,
  input  logic [COL_W-1:0]             cmp_col_i,
  input  logic                         alt_live_i,
  output logic signed [SCORE_W-1:0]    best_o,
  output logic [COL_W-1:0]             best_col_o,
  output logic                         found_o
);
  import gcpm_pkg::*;

  logic signed [VALUE_BITS-1:0]   alt_mem [MAX_ROWS];
  logic signed [VALUE_BITS-1:0]   alt_rd_q;
  logic signed [2*VALUE_BITS-1:0] prod_q;
  logic signed [SCORE_W-1:0]      acc_q;
  logic signed [SCORE_W-1:0]      score_mem [MAX_COLS];
  logic signed [SCORE_W-1:0]      score_rd_q;
  logic signed [SCORE_W-1:0]      best_q;
  logic [COL_W-1:0]               best_col_q;
  logic                           found_q;

  always_ff @(posedge clk_i) begin
    if (alt_we_i) begin
      alt_mem[alt_waddr_i] <= alt_wdata_i;
    end
    if (ctl_i.issue) begin
      alt_rd_q <= alt_mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= alt_rd_q * ref_rd_i;
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + SCORE_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.score_wr) begin
      score_mem[col_i] <= acc_q;
    end
    if (ctl_i.scan_rd) begin
      score_rd_q <= score_mem[col_i];
    end
  end

  // Strictly greater wins, so the first maximum in ascending reference order stays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_q     <= '0;
      best_col_q <= '0;
    end else if (ctl_i.scan_clr) begin
      found_q    <= 1'b0;
      best_q     <= '0;
      best_col_q <= '0;
    end else if (ctl_i.scan_cmp && alt_live_i && (score_rd_q > best_q)) begin
      found_q    <= 1'b1;
      best_q     <= score_rd_q;
      best_col_q <= cmp_col_i;
    end
  end

  assign best_o     = best_q;
  assign best_col_o = best_col_q;
  assign found_o    = found_q;

endmodule

// ===== rtl/core/gcpm_merge.sv =====
// Merging stage of the matcher: walks the lane results one lane per cycle and
// keeps the row-major first maximum; falls back to the lowest free columns.
// Depends on gcpm_pkg.
module gcpm_merge #(
  parameter int MAX_COLS = 16,
  parameter int SCORE_W  = 40,
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [MAX_COLS-1:0][SCORE_W-1:0]  best_i,
  input  logic [MAX_COLS-1:0][COL_W-1:0]    best_col_i,
  input  logic [MAX_COLS-1:0]               found_i,
  input  logic [MAX_COLS-1:0]               ref_rem_i,
  input  logic [MAX_COLS-1:0]               alt_rem_i,
  output logic                              busy_o,
  output logic [COL_W-1:0]                  res_ref_o,
  output logic [COL_W-1:0]                  res_alt_o
);
  import gcpm_pkg::*;

  logic [COL_W-1:0]          idx_q;
  logic                      busy_q;
  logic                      have_q;
  logic signed [SCORE_W-1:0] cur_q;
  logic [COL_W-1:0]          cur_ref_q;
  logic [COL_W-1:0]          cur_alt_q;
  logic signed [SCORE_W-1:0] cand;
  logic                      take;
  logic [COL_W-1:0]          low_ref;
  logic [COL_W-1:0]          low_alt;

  assign cand = $signed(best_i[idx_q]);
  assign take = found_i[idx_q] &&
                (!have_q || (cand > cur_q) ||
                 ((cand == cur_q) && (best_col_i[idx_q] < cur_ref_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      busy_q    <= 1'b0;
      have_q    <= 1'b0;
      cur_q     <= '0;
      cur_ref_q <= '0;
      cur_alt_q <= '0;
    end else if (start_i) begin
      idx_q  <= '0;
      busy_q <= 1'b1;
      have_q <= 1'b0;
    end else if (busy_q) begin
      if (take) begin
        have_q    <= 1'b1;
        cur_q     <= cand;
        cur_ref_q <= best_col_i[idx_q];
        cur_alt_q <= idx_q;
      end
      if (idx_q == COL_W'(MAX_COLS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    low_ref = '0;
    low_alt = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (ref_rem_i[i]) begin
        low_ref = COL_W'(i);
      end
      if (alt_rem_i[i]) begin
        low_alt = COL_W'(i);
      end
    end
  end

  assign busy_o    = busy_q;
  assign res_ref_o = have_q ? cur_ref_q : low_ref;
  assign res_alt_o = have_q ? cur_alt_q : low_alt;

endmodule

// ===== rtl/core/greedy_column_pair_matcher.sv =====
// Top level of the greedy column pair matcher: sequencer, reference store,
// configuration registers, the lane array and the merging stage.
// Depends on gcpm_pkg, gcpm_lane and gcpm_merge.
//
// Usage. Each input beat writes one reference and one alternative element at
// (row_index, col_index); indexes beyond the store are dropped. Load beats are
// taken one per cycle while the block is loading. The beat with load_done set
// starts a run: from then on in_stall_o stays high until the run is over.
// A run first forms every column dot product. For each reference column one
// MAC lane per alternative column streams the rows; the reference columns take
// turns, set by the single read port of the reference store. Then each of cols
// rounds scans the scores of all lanes, merges the lanes one per cycle and
// emits one result beat.
// Results leave through an output register; while the receiver stalls, the
// round waits in its emit step and the held beat does not change. New load
// beats are taken again as soon as the last pair sits in the output register.
// Reset clears the sequencer, sets the column masks to all ones and sets the
// registers to their defaults; the element stores hold garbage until written.
module greedy_column_pair_matcher #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gcpm_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gcpm_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [gcpm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gcpm_pkg::*;

  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W  = $clog2(MAX_COLS + 1);
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCORE_W = 2 * VALUE_BITS + $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_SCWR,
    ST_SCAN,
    ST_SCAN_END,
    ST_MERGE_GO,
    ST_MERGE_WAIT,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [ROW_W-1:0]    r_q;
  logic [COL_W-1:0]    a_q;
  logic [COL_W-1:0]    round_q;
  logic [COL_W-1:0]    cmp_col_q;
  logic [RCNT_W-1:0]   rows_run_q;
  logic [CCNT_W-1:0]   cols_run_q;
  logic [MAX_COLS-1:0] ref_rem_q;
  logic [MAX_COLS-1:0] alt_rem_q;
  logic                issue_q1;
  logic                issue_q2;
  logic                scan_q1;
  logic                out_valid_q;
  out_t                out_q;
  logic [8:0]          rows_cfg_q;
  logic [4:0]          cols_cfg_q;

  logic                         in_fire;
  logic                         in_ok;
  logic                         start;
  logic [RCNT_W-1:0]            rows_sat;
  logic [CCNT_W-1:0]            cols_sat;
  logic [MAX_COLS-1:0]          col_mask;
  logic                         last_row;
  logic                         last_col;
  logic                         last_round;
  logic                         out_free;
  logic                         emit_fire;
  lane_ctl_t                    ctl;
  logic signed [VALUE_BITS-1:0] ref_mem [DEPTH];
  logic signed [VALUE_BITS-1:0] ref_rd_q;
  logic [ADDR_W-1:0]            ref_waddr;
  logic [ADDR_W-1:0]            ref_raddr;
  logic [ROW_W-1:0]             alt_waddr;
  logic signed [VALUE_BITS-1:0] ref_wdata;
  logic signed [VALUE_BITS-1:0] alt_wdata;

  logic [MAX_COLS-1:0][SCORE_W-1:0] lane_best;
  logic [MAX_COLS-1:0][COL_W-1:0]   lane_best_col;
  logic [MAX_COLS-1:0]              lane_found;
  logic                             merge_busy;
  logic [COL_W-1:0]                 res_ref;
  logic [COL_W-1:0]                 res_alt;

  // Input side: beats are only taken while loading.
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_ok      = (int'(in_data_i.row_index) < MAX_ROWS) &&
                      (int'(in_data_i.col_index) < MAX_COLS);
  assign start      = in_fire && in_data_i.load_done;

  // Only the low VALUE_BITS of each element count.
  assign ref_wdata = VALUE_BITS'($unsigned(in_data_i.ref_value));
  assign alt_wdata = VALUE_BITS'($unsigned(in_data_i.alt_value));
  assign alt_waddr = ROW_W'(in_data_i.row_index);
  assign ref_waddr = ADDR_W'(int'(in_data_i.row_index) * MAX_COLS +
                             int'(in_data_i.col_index));
  assign ref_raddr = ADDR_W'(int'(r_q) * MAX_COLS + int'(a_q));

  // Register values are saturated into their legal ranges when a run starts.
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_sat = RCNT_W'(1);
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      rows_sat = RCNT_W'(MAX_ROWS);
    end else begin
      rows_sat = RCNT_W'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_sat = CCNT_W'(1);
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      cols_sat = CCNT_W'(MAX_COLS);
    end else begin
      cols_sat = CCNT_W'(cols_cfg_q);
    end
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (i < int'(cols_sat));
    end
  end

  assign last_row   = (r_q == ROW_W'(rows_run_q - 1'b1));
  assign last_col   = (a_q == COL_W'(cols_run_q - 1'b1));
  assign last_round = (round_q == COL_W'(cols_run_q - 1'b1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;

  // Lane controls.
  always_comb begin
    ctl          = '0;
    ctl.issue    = (state_q == ST_MAC);
    ctl.mul_en   = issue_q1;
    ctl.acc_en   = issue_q2;
    ctl.acc_clr  = start || (state_q == ST_SCWR);
    ctl.score_wr = (state_q == ST_SCWR);
    ctl.scan_rd  = (state_q == ST_SCAN);
    ctl.scan_clr = (state_q == ST_SCAN) && (a_q == '0);
    ctl.scan_cmp = scan_q1;
  end

  // Reference store: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_fire && in_ok) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (ctl.issue) begin
      ref_rd_q <= ref_mem[ref_raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 9'd256;
      cols_cfg_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_IN_USE: rows_cfg_q <= cfg_data_i;
        CFG_COLS_IN_USE: cols_cfg_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      r_q         <= '0;
      a_q         <= '0;
      round_q     <= '0;
      cmp_col_q   <= '0;
      rows_run_q  <= '0;
      cols_run_q  <= '0;
      ref_rem_q   <= '1;
      alt_rem_q   <= '1;
      issue_q1    <= 1'b0;
      issue_q2    <= 1'b0;
      scan_q1     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      issue_q1  <= ctl.issue;
      issue_q2  <= issue_q1;
      scan_q1   <= (state_q == ST_SCAN) && ref_rem_q[a_q];
      cmp_col_q <= a_q;
      if (out_valid_q && !out_stall_i && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (start) begin
            rows_run_q <= rows_sat;
            cols_run_q <= cols_sat;
            ref_rem_q  <= col_mask;
            alt_rem_q  <= col_mask;
            r_q        <= '0;
            a_q        <= '0;
            state_q    <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (last_row) begin
            r_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!issue_q1 && !issue_q2) begin
            state_q <= ST_SCWR;
          end
        end
        ST_SCWR: begin
          if (last_col) begin
            a_q     <= '0;
            round_q <= '0;
            state_q <= ST_SCAN;
          end else begin
            a_q     <= a_q + 1'b1;
            state_q <= ST_MAC;
          end
        end
        ST_SCAN: begin
          if (last_col) begin
            a_q     <= '0;
            state_q <= ST_SCAN_END;
          end else begin
            a_q <= a_q + 1'b1;
          end
        end
        ST_SCAN_END: begin
          state_q <= ST_MERGE_GO;
        end
        ST_MERGE_GO: begin
          state_q <= ST_MERGE_WAIT;
        end
        ST_MERGE_WAIT: begin
          if (!merge_busy) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.ref_col      <= 5'(32'(res_ref) + 1);
            out_q.alt_col      <= 5'(32'(res_alt) + 1);
            out_q.last_pair    <= last_round;
            ref_rem_q[res_ref] <= 1'b0;
            alt_rem_q[res_alt] <= 1'b0;
            if (last_round) begin
              state_q <= ST_LOAD;
            end else begin
              round_q <= round_q + 1'b1;
              a_q     <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One lane per alternative column.
  for (genvar g = 0; g < MAX_COLS; g++) begin : g_lane
    logic signed [SCORE_W-1:0] best;

    gcpm_lane #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .VALUE_BITS(VALUE_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .alt_we_i   (in_fire && in_ok && (int'(in_data_i.col_index) == g)),
      .alt_waddr_i(alt_waddr),
      .alt_wdata_i(alt_wdata),
      .rd_row_i   (r_q),
      .ref_rd_i   (ref_rd_q),
      .col_i      (a_q),
      .cmp_col_i  (cmp_col_q),
      .alt_live_i (alt_rem_q[g]),
      .best_o     (best),
      .best_col_o (lane_best_col[g]),
      .found_o    (lane_found[g])
    );

    assign lane_best[g] = best;
  end

  gcpm_merge #(
    .MAX_COLS(MAX_COLS),
    .SCORE_W (SCORE_W)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_MERGE_GO),
    .best_i    (lane_best),
    .best_col_i(lane_best_col),
    .found_i   (lane_found),
    .ref_rem_i (ref_rem_q),
    .alt_rem_i (alt_rem_q),
    .busy_o    (merge_busy),
    .res_ref_o (res_ref),
    .res_alt_o (res_alt)
  );

`ifndef SYNTHESIS
  // A pair is only ever formed from columns that are still free.
  a_ref_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> ref_rem_q[res_ref])
    else $error("paired reference column was already taken");

  a_alt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> alt_rem_q[res_alt])
    else $error("paired alternative column was already taken");

  // Both masks hold the same number of free columns, since each pair takes one from each.
  a_mask_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(ref_rem_q) == $countones(alt_rem_q))
    else $error("free column masks out of balance");

  // After the last pair every column of the run is used up.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && last_round |=> (ref_rem_q == '0) && (alt_rem_q == '0))
    else $error("columns left free after the last pair");

  // The merge never runs while the lanes are still scanning or scoring.
  a_merge_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_busy |-> (state_q == ST_MERGE_WAIT))
    else $error("merge busy outside its wait step");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for greedy_column_pair_matcher.
// Loads matrix pairs, predicts the greedy column pairing of every run and checks each result beat.
// Depends on gcpm_pkg and the greedy_column_pair_matcher RTL.
`timescale 1ns / 1ps

module tb;
  import gcpm_pkg::*;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 40;
  localparam int SETTLE     = 30;
  localparam int LONG_HOLD  = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic                  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  greedy_column_pair_matcher u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Load beats waiting for the driver, and pairs the matcher still owes us.
  in_t  load_q[$];
  out_t pair_q[$];

  // Our own copy of the matrices and the register values, as the block sees them.
  logic signed [15:0] ref_mem[MAX_ROWS*MAX_COLS];
  logic signed [15:0] alt_mem[MAX_ROWS*MAX_COLS];
  logic [8:0]         rows_reg;
  logic [4:0]         cols_reg;

  // Which store entries the stimulus has already written; a run never reads one that is not.
  bit written[MAX_ROWS][MAX_COLS];

  bit burst;        // when set, neither side idles
  int n_fail;
  int n_beats_in;
  int n_pairs;
  int n_runs;

  always #2 clk = ~clk;

  // Pairs columns the way the matcher does once the load_done beat lands. The beat's own
  // element is written first, so it takes part in its own run.
  task automatic match_columns(input in_t b);
    longint  score[MAX_COLS][MAX_COLS];
    longint  best;
    longint  acc;
    int      rows;
    int      cols;
    int      ba;
    int      bb;
    bit      seen;
    bit [15:0] ref_free;
    bit [15:0] alt_free;
    out_t    p;
    ref_mem[b.row_index*MAX_COLS + b.col_index] = b.ref_value;
    alt_mem[b.row_index*MAX_COLS + b.col_index] = b.alt_value;
    if (!b.load_done) return;
    // Out-of-range register values are clamped when the run starts.
    rows = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
    cols = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
    for (int a = 0; a < cols; a++) begin
      for (int c = 0; c < cols; c++) begin
        acc = 0;
        for (int r = 0; r < rows; r++) begin
          acc += longint'(ref_mem[r*MAX_COLS + a]) * longint'(alt_mem[r*MAX_COLS + c]);
        end
        score[a][c] = acc;
      end
    end
    ref_free = '1;
    alt_free = '1;
    for (int k = 0; k < cols; k++) begin
      // The running best starts at zero, so with no positive score left the first free
      // pair in scan order wins. Only a strictly greater score displaces the best.
      best = 0;
      seen = 0;
      ba   = 0;
      bb   = 0;
      for (int a = 0; a < cols; a++) begin
        if (!ref_free[a]) continue;
        for (int c = 0; c < cols; c++) begin
          if (!alt_free[c]) continue;
          if (!seen) begin
            seen = 1;
            ba   = a;
            bb   = c;
          end
          if (score[a][c] > best) begin
            best = score[a][c];
            ba   = a;
            bb   = c;
          end
        end
      end
      ref_free[ba] = 0;
      alt_free[bb] = 0;
      p.ref_col   = 5'(ba + 1);
      p.alt_col   = 5'(bb + 1);
      p.last_pair = (k == cols - 1);
      pair_q.push_back(p);
    end
  endtask

  // Driver: offers queued load beats with a random gap after each one.
  int gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        match_columns(in_data);
        n_beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (load_q.size() > 0) begin
          in_data  <= load_q.pop_front();
          in_valid <= 1'b1;
          gap_left = burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted pair against the oldest expectation and draws a stall
  // before the next one. Once, it holds off for a long stretch so the block backs up.
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_pairs++;
        if (pair_q.size() == 0) begin
          $error("unexpected pair ref_col=%0d alt_col=%0d", out_data.ref_col, out_data.alt_col);
          n_fail++;
        end else begin
          if (out_data.ref_col !== pair_q[0].ref_col) begin
            $error("ref_col expected %0d actual %0d", pair_q[0].ref_col, out_data.ref_col);
            n_fail++;
          end
          if (out_data.alt_col !== pair_q[0].alt_col) begin
            $error("alt_col expected %0d actual %0d", pair_q[0].alt_col, out_data.alt_col);
            n_fail++;
          end
          if (out_data.last_pair !== pair_q[0].last_pair) begin
            $error("last_pair expected %0d actual %0d", pair_q[0].last_pair,
                   out_data.last_pair);
            n_fail++;
          end
          void'(pair_q.pop_front());
        end
        if (n_pairs == 40) stall_left = LONG_HOLD;
        else stall_left = burst ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any stretch this long with no beat moving on either side is a hang.
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_ROWS_IN_USE) rows_reg = val;
    else cols_reg = val[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until the matcher has delivered everything and has had time to settle.
  task automatic drain();
    while (load_q.size() > 0 || in_valid || pair_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic in_t load_beat(input int r, input int c, input int mode, input bit done);
    in_t b;
    b.row_index = 8'(r);
    b.col_index = 4'(c);
    b.ref_value = pick_value(mode);
    b.alt_value = pick_value(mode);
    b.load_done = done;
    written[r][c] = 1;
    return b;
  endfunction

  // Queues one run: every entry the run reads that is still unwritten, a few stray writes
  // anywhere in the store, and the load_done beat last, at a random entry inside the run.
  task automatic queue_run(input int mode, input int extra);
    int rows;
    int cols;
    rows = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
    cols = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (!written[r][c]) load_q.push_back(load_beat(r, c, mode, 0));
      end
    end
    repeat (extra) begin
      load_q.push_back(load_beat($urandom_range(0, MAX_ROWS-1), $urandom_range(0, MAX_COLS-1),
                                 mode, 0));
    end
    load_q.push_back(load_beat($urandom_range(0, rows-1), $urandom_range(0, cols-1), mode, 1));
    n_runs++;
  endtask

  initial begin
    logic [8:0] rv;
    logic [4:0] cv;
    clk      = 1'b0;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_ROWS_IN_USE;
    cfg_data = '0;
    burst    = 1'b0;
    rows_reg = 9'd256;
    cols_reg = 5'd16;
    n_fail   = 0;
    n_pairs  = 0;
    n_runs   = 0;
    n_beats_in = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // One row, every column, extreme values; the column count above its maximum is clamped.
    write_reg(CFG_ROWS_IN_USE, 9'd1);
    write_reg(CFG_COLS_IN_USE, 9'd31);
    queue_run(2, 0);
    drain();
    // Both registers at zero clamp to a single one-by-one run.
    write_reg(CFG_ROWS_IN_USE, 9'd0);
    write_reg(CFG_COLS_IN_USE, 9'd0);
    queue_run(2, 0);
    drain();
    // Tiny values give ties, zero and negative scores, so the fallback pairing shows up.
    write_reg(CFG_ROWS_IN_USE, 9'd3);
    write_reg(CFG_COLS_IN_USE, 9'd2);
    queue_run(1, 0);
    drain();

    // Random part: new registers, then two runs queued back to back so that the second
    // one's beats wait at the stalled input while the first is matching.
    while (n_beats_in + load_q.size() < 170) begin
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       rv = 9'($urandom_range(9, 16));
        1:       rv = 9'd0;
        default: rv = 9'($urandom_range(1, 8));
      endcase
      cv = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
      // Keep the load cost of a wide, deep run modest.
      if (rv > 8 && cv > 4) cv = 5'($urandom_range(1, 4));
      write_reg(CFG_ROWS_IN_USE, rv);
      write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(cv));
      queue_run($urandom_range(0, 2), $urandom_range(0, 3));
      queue_run($urandom_range(0, 2), $urandom_range(0, 3));
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (pair_q.size() > 0) begin
      $error("%0d expected pairs never arrived", pair_q.size());
      n_fail++;
    end
    $display("Ran %0d matching runs from %0d load beats and checked %0d column pairs,",
             n_runs, n_beats_in, n_pairs);
    $display("with register values from zero past their maximum and idle stalls on both sides.");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
